// ===== rtl/core/pee_pkg.sv =====
// Shared types and constants for the postfix expression evaluator.
`timescale 1ns / 1ps

package pee_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] op_t;
    typedef logic [1:0] err_t;

    localparam byte_t CH_PLUS  = 8'h2B;
    localparam byte_t CH_MINUS = 8'h2D;
    localparam byte_t CH_STAR  = 8'h2A;
    localparam byte_t CH_SLASH = 8'h2F;
    localparam byte_t CH_CARET = 8'h5E;
    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_SPACE = 8'h20;

    localparam op_t OP_ADD = 3'd0;
    localparam op_t OP_SUB = 3'd1;
    localparam op_t OP_MUL = 3'd2;
    localparam op_t OP_DIV = 3'd3;
    localparam op_t OP_POW = 3'd4;

    localparam err_t ERR_NONE      = 2'd0;
    localparam err_t ERR_DIV_ZERO  = 2'd1;
    localparam err_t ERR_UNDERFLOW = 2'd2;
    localparam err_t ERR_OVERFLOW  = 2'd3;

    // Shift control type used by each stack cell.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

    function automatic op_t op_of(input byte_t c);
        op_t o;
        o = OP_ADD;
        case (c)
            CH_PLUS:  o = OP_ADD;
            CH_MINUS: o = OP_SUB;
            CH_STAR:  o = OP_MUL;
            CH_SLASH: o = OP_DIV;
            CH_CARET: o = OP_POW;
            default:  o = OP_ADD;
        endcase
        return o;
    endfunction

endpackage

// ===== rtl/core/pee_cell.sv =====
// One byte-wide stack cell that shifts toward or away from the top.
`timescale 1ns / 1ps

module pee_cell (
    input  logic               aclk,
    input  pee_pkg::cell_ctl_t ctl,
    input  pee_pkg::byte_t     above_in,
    input  pee_pkg::byte_t     below_in,
    output pee_pkg::byte_t     q
);
    import pee_pkg::*;

    byte_t data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            data_reg <= above_in;
        end else if (ctl.pop) begin
            data_reg <= below_in;
        end
    end

    assign q = data_reg;

endmodule

// ===== rtl/core/pee_alu.sv =====
// Arithmetic unit: add, subtract, multiply, divide and power on bytes; divide and power iterate.
`timescale 1ns / 1ps

module pee_alu (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  pee_pkg::op_t   op,
    input  pee_pkg::byte_t lhs,
    input  pee_pkg::byte_t rhs,
    output logic           done,
    output pee_pkg::byte_t result,
    output logic           div_zero
);
    import pee_pkg::*;

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_DIV  = 2'd1;
    localparam logic [1:0] A_POW  = 2'd2;

    logic [1:0] state_reg;
    logic       done_reg;
    logic       dz_reg;
    byte_t      res_reg;
    byte_t      acc_reg;
    byte_t      base_reg;
    byte_t      exp_reg;
    byte_t      dvd_reg;
    byte_t      dsr_reg;
    byte_t      rem_reg;
    logic [2:0] step_reg;
    logic       neg_reg;

    logic [8:0] rem_sh;
    logic       ge;
    byte_t      rem_next;
    byte_t      quo_next;
    byte_t      lhs_mag;
    byte_t      rhs_mag;
    logic [15:0] prod_ab;
    logic [15:0] prod_acc;
    logic [15:0] prod_sq;

    // Restoring division, one quotient bit per cycle.
    assign rem_sh   = {rem_reg, dvd_reg[7]};
    assign ge       = rem_sh >= {1'b0, dsr_reg};
    assign rem_next = ge ? 8'(rem_sh - {1'b0, dsr_reg}) : rem_sh[7:0];
    assign quo_next = {dvd_reg[6:0], ge};

    assign lhs_mag  = lhs[7] ? 8'(-lhs) : lhs;
    assign rhs_mag  = rhs[7] ? 8'(-rhs) : rhs;
    assign prod_ab  = lhs * rhs;
    assign prod_acc = acc_reg * base_reg;
    assign prod_sq  = base_reg * base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE: begin
                    if (start) begin
                        dz_reg <= 1'b0;
                        case (op)
                            OP_ADD: begin
                                res_reg  <= 8'(lhs + rhs);
                                done_reg <= 1'b1;
                            end
                            OP_SUB: begin
                                res_reg  <= 8'(lhs - rhs);
                                done_reg <= 1'b1;
                            end
                            OP_MUL: begin
                                res_reg  <= prod_ab[7:0];
                                done_reg <= 1'b1;
                            end
                            OP_DIV: begin
                                if (rhs == 8'd0) begin
                                    res_reg  <= 8'd0;
                                    dz_reg   <= 1'b1;
                                    done_reg <= 1'b1;
                                end else begin
                                    dvd_reg   <= lhs_mag;
                                    dsr_reg   <= rhs_mag;
                                    rem_reg   <= 8'd0;
                                    step_reg  <= 3'd0;
                                    neg_reg   <= lhs[7] ^ rhs[7];
                                    state_reg <= A_DIV;
                                end
                            end
                            OP_POW: begin
                                if (rhs[7]) begin
                                    // A negative exponent only survives for a base of one
                                    // or minus one.
                                    if (lhs == 8'h01) begin
                                        res_reg <= 8'h01;
                                    end else if (lhs == 8'hFF) begin
                                        res_reg <= rhs[0] ? 8'hFF : 8'h01;
                                    end else begin
                                        res_reg <= 8'd0;
                                    end
                                    done_reg <= 1'b1;
                                end else begin
                                    acc_reg   <= 8'd1;
                                    base_reg  <= lhs;
                                    exp_reg   <= rhs;
                                    state_reg <= A_POW;
                                end
                            end
                            default: begin
                                res_reg  <= 8'd0;
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                A_DIV: begin
                    rem_reg  <= rem_next;
                    dvd_reg  <= quo_next;
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd7) begin
                        res_reg   <= neg_reg ? 8'(-quo_next) : quo_next;
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                A_POW: begin
                    if (exp_reg == 8'd0) begin
                        res_reg   <= acc_reg;
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end else begin
                        if (exp_reg[0]) begin
                            acc_reg <= prod_acc[7:0];
                        end
                        base_reg <= prod_sq[7:0];
                        exp_reg  <= {1'b0, exp_reg[7:1]};
                    end
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    assign done     = done_reg;
    assign result   = res_reg;
    assign div_zero = dz_reg;

endmodule

// ===== rtl/core/postfix_expression_evaluator_core.sv =====
// Top level of the postfix expression evaluator: cell-chain stack, sequencer and ALU.
`timescale 1ns / 1ps

// Evaluates a postfix expression fed one ASCII character per beat, with tlast on the
// final character; one result beat (value and error code) follows each expression.
// The operand stack is a chain of STACK_DEPTH byte cells with the top in the first
// cell: a push shifts every cell down by one, an operator writes its result into the
// first cell and shifts the rest up. Items are taken one at a time: a character is
// accepted in idle, then passes through execute and, for an operator with enough
// operands, a wait on the ALU, and ends in a finish state before ready returns. The
// ALU answers add, subtract, multiply, a divide by zero and a negative exponent
// without iterating; divide iterates per quotient bit, power per significant exponent bit.
// The final character waits in the finish state while the previous result beat is unread.
module postfix_expression_evaluator_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] value, [9:8] error, [15:10] zero
);
    import pee_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    err_t           err_reg, err_next;
    byte_t          ch_reg;
    logic           last_reg;
    logic           m_valid_reg, m_valid_next;
    byte_t          m_value_reg;
    err_t           m_err_reg;

    byte_t          cell_q [STACK_DEPTH];
    cell_ctl_t      cell_ctl [STACK_DEPTH];
    byte_t          top_in;

    logic           is_op;
    logic           is_space;
    logic           full;
    logic           enough;
    logic           push_go;
    logic           alu_start;
    logic           alu_done;
    byte_t          alu_res;
    logic           alu_dz;
    logic           emit;

    assign is_op    = ch_reg inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
    assign is_space = ch_reg == CH_SPACE;
    assign full     = count_reg == CNT_W'(STACK_DEPTH);
    assign enough   = count_reg >= CNT_W'(2);
    assign push_go  = (state_reg == ST_EXEC) && !is_op && !is_space && !full;
    assign alu_start = (state_reg == ST_EXEC) && is_op && enough;
    assign emit     = (state_reg == ST_FIN) && last_reg && (!m_valid_reg || m_tready);

    pee_alu u_alu (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (alu_start),
        .op       (op_of(ch_reg)),
        .lhs      (cell_q[1]),
        .rhs      (cell_q[0]),
        .done     (alu_done),
        .result   (alu_res),
        .div_zero (alu_dz)
    );

    // The top cell takes either a new operand or the ALU result; the others shift.
    assign top_in = alu_done ? alu_res : 8'(ch_reg - CH_ZERO);

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_top
                assign cell_ctl[gi] = '{push: push_go || alu_done, pop: 1'b0};
                pee_cell u_cell (
                    .aclk     (aclk),
                    .ctl      (cell_ctl[gi]),
                    .above_in (top_in),
                    .below_in (cell_q[gi]),
                    .q        (cell_q[gi])
                );
            end else if (gi == STACK_DEPTH - 1) begin : g_bottom
                assign cell_ctl[gi] = '{push: push_go, pop: alu_done};
                pee_cell u_cell (
                    .aclk     (aclk),
                    .ctl      (cell_ctl[gi]),
                    .above_in (cell_q[gi-1]),
                    .below_in (cell_q[gi]),
                    .q        (cell_q[gi])
                );
            end else begin : g_mid
                assign cell_ctl[gi] = '{push: push_go, pop: alu_done};
                pee_cell u_cell (
                    .aclk     (aclk),
                    .ctl      (cell_ctl[gi]),
                    .above_in (cell_q[gi-1]),
                    .below_in (cell_q[gi+1]),
                    .q        (cell_q[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (is_op) begin
                    if (enough) begin
                        state_next = ST_WAIT;
                    end else begin
                        if (err_reg == ERR_NONE) err_next = ERR_UNDERFLOW;
                        state_next = ST_FIN;
                    end
                end else if (is_space) begin
                    state_next = ST_FIN;
                end else begin
                    if (full) begin
                        if (err_reg == ERR_NONE) err_next = ERR_OVERFLOW;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_FIN;
                end
            end
            ST_WAIT: begin
                if (alu_done) begin
                    count_next = count_reg - CNT_W'(1);
                    if (alu_dz && err_reg == ERR_NONE) err_next = ERR_DIV_ZERO;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (emit) begin
                    m_valid_next = 1'b1;
                    count_next   = '0;
                    err_next     = ERR_NONE;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            err_reg     <= ERR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg   <= s_tdata;
            last_reg <= s_tlast;
        end
        if (emit) begin
            // An empty stack reports zero and counts as underflow unless an error is held.
            m_value_reg <= (count_reg == '0) ? 8'd0 : cell_q[0];
            m_err_reg   <= (count_reg == '0 && err_reg == ERR_NONE) ? ERR_UNDERFLOW : err_reg;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_err_reg, m_value_reg};

endmodule

// ===== rtl/core/pee_checker.sv =====
// Port-level checks for the postfix expression evaluator, bound to the top level.
`timescale 1ns / 1ps

module pee_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The pad bits above the error code are always zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:10] == 6'd0)
        else $error("result pad bits not zero");

    // Each character is processed before the next is taken, so ready drops right after a beat.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A new result only appears after a character marked last has been taken.
    a_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast |=> ##1 !$rose(m_tvalid))
        else $error("result without a final character");

endmodule

bind postfix_expression_evaluator_core pee_checker u_pee_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
